FILE: hw/rtl/set_ua_link_setup_sender_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SET/UA link-setup sender.
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SET_UA_LINK_SETUP_SENDER_CORE_MACROS_SVH
`define SET_UA_LINK_SETUP_SENDER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SUA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sua assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SUA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sua assertion failed");
`else
`define SUA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SUA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/sua_pkg.sv
// ----------------------------------------------------------------------------
// SET/UA link-setup sender package
// Shared types, request and status codes, and register indexes.
// ----------------------------------------------------------------------------
package sua_pkg;

	localparam int FRAME_LENGTH = 5;
	localparam int BEAT_W       = $clog2(FRAME_LENGTH);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_CONN = 2'd2;
	localparam logic [1:0] PH_FAIL = 2'd3;

	localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
	localparam logic [2:0] CFG_MAX_ATT  = 3'd1;
	localparam logic [2:0] CFG_ADDRESS  = 3'd2;
	localparam logic [2:0] CFG_SET_CTRL = 3'd3;
	localparam logic [2:0] CFG_UA_CTRL  = 3'd4;
	localparam logic [2:0] CFG_FLAG     = 3'd5;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [3:0]  max_attempts;
		logic [7:0]  link_address;
		logic [7:0]  set_control;
		logic [7:0]  ua_control;
		logic [7:0]  flag_byte;
	} cfg_t;

	// Outcome of one request: send a SET frame or a single status beat.
	typedef struct packed {
		logic       frame;
		logic [1:0] status;
	} res_t;

	typedef enum logic [4:0] {
		PS_FLAG = 5'b00001,
		PS_ADDR = 5'b00010,
		PS_CTRL = 5'b00100,
		PS_BCC  = 5'b01000,
		PS_END  = 5'b10000
	} parse_t;

endpackage

FILE: hw/rtl/sua_ctrl.sv
// ----------------------------------------------------------------------------
// SET/UA control
// Link phase, UA frame parser, retransmission timer and attempt counter.
// ----------------------------------------------------------------------------
`include "set_ua_link_setup_sender_core_macros.svh"

module sua_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  sua_pkg::cfg_t cfg,
	input  logic          fire,
	input  logic [1:0]    req_type,
	input  logic [7:0]    rx_byte,
	output sua_pkg::res_t res
);
	import sua_pkg::*;

	parse_t      parse_q, parse_d;
	logic [1:0]  phase_q, phase_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  attempt_q, attempt_d;
	logic        frame;
	logic [15:0] timer_inc;
	logic [3:0]  attempt_inc;
	logic [3:0]  limit;
	logic [7:0]  ua_bcc;

	assign timer_inc   = timer_q + 16'd1;
	assign attempt_inc = attempt_q + 4'd1;
	assign limit       = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
	assign ua_bcc      = cfg.link_address ^ cfg.ua_control;

	always_comb begin
		parse_d   = parse_q;
		phase_d   = phase_q;
		timer_d   = timer_q;
		attempt_d = attempt_q;
		frame     = 1'b0;
		case (req_type)
			REQ_START: begin
				parse_d   = PS_FLAG;
				attempt_d = 4'd0;
				phase_d   = PH_WAIT;
				timer_d   = 16'd0;
				frame     = 1'b1;
			end
			REQ_BYTE: begin
				if (phase_q == PH_WAIT) begin
					unique case (parse_q)
						PS_FLAG: begin
							if (rx_byte == cfg.flag_byte) parse_d = PS_ADDR;
						end
						PS_ADDR: begin
							if (rx_byte == cfg.link_address) parse_d = PS_CTRL;
							else if (rx_byte != cfg.flag_byte) parse_d = PS_FLAG;
						end
						PS_CTRL: begin
							if (rx_byte == cfg.ua_control) parse_d = PS_BCC;
							else if (rx_byte == cfg.flag_byte) parse_d = PS_ADDR;
							else parse_d = PS_FLAG;
						end
						PS_BCC: begin
							if (rx_byte == ua_bcc) parse_d = PS_END;
							else if (rx_byte == cfg.flag_byte) parse_d = PS_ADDR;
							else parse_d = PS_FLAG;
						end
						PS_END: begin
							if (rx_byte == cfg.flag_byte) begin
								phase_d = PH_CONN;
								timer_d = 16'd0;
							end
							parse_d = PS_FLAG;
						end
						default: parse_d = PS_FLAG;
					endcase
				end
			end
			REQ_TICK: begin
				if (phase_q == PH_WAIT) begin
					timer_d = timer_inc;
					if (timer_inc >= cfg.timeout_ticks) begin
						timer_d   = 16'd0;
						attempt_d = attempt_inc;
						if (attempt_inc >= limit) phase_d = PH_FAIL;
						else frame = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q   <= PS_FLAG;
			phase_q   <= PH_IDLE;
			timer_q   <= 16'd0;
			attempt_q <= 4'd0;
		end else if (fire) begin
			parse_q   <= parse_d;
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			attempt_q <= attempt_d;
		end
	end

	assign res.frame  = frame;
	assign res.status = phase_d;

	`SUA_ASSERT_NEXT(a_start_clears, clk, arst_n, fire && req_type == REQ_START, phase_q == PH_WAIT && parse_q == PS_FLAG && attempt_q == 4'd0)
	`SUA_ASSERT_IMPL(a_conn_parser_idle, clk, arst_n, phase_q == PH_CONN, parse_q == PS_FLAG)

endmodule

FILE: hw/rtl/sua_tx_seq.sv
// ----------------------------------------------------------------------------
// SET/UA result sequencer
// Result register that plays out a five-beat SET frame or one status beat.
// ----------------------------------------------------------------------------
`include "set_ua_link_setup_sender_core_macros.svh"

module sua_tx_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  sua_pkg::cfg_t cfg,
	input  logic          load,
	input  sua_pkg::res_t res,
	output logic          free,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,  // [7:0] tx_byte, [9:8] link_status, rest zero
	output logic          m_axis_tuser,  // [0] tx_valid
	output logic          m_axis_tlast
);
	import sua_pkg::*;

	localparam logic [BEAT_W-1:0] BEAT_FLAG_OPEN  = BEAT_W'(0);
	localparam logic [BEAT_W-1:0] BEAT_ADDR       = BEAT_W'(1);
	localparam logic [BEAT_W-1:0] BEAT_CTRL       = BEAT_W'(2);
	localparam logic [BEAT_W-1:0] BEAT_BCC        = BEAT_W'(3);
	localparam logic [BEAT_W-1:0] BEAT_FLAG_CLOSE = BEAT_W'(FRAME_LENGTH - 1);

	logic              valid_q;
	logic              frame_q;
	logic [1:0]        status_q;
	logic [BEAT_W-1:0] beat_q;
	logic              last_beat;
	logic [7:0]        frame_byte;

	assign last_beat = !frame_q || (beat_q == BEAT_FLAG_CLOSE);
	assign free      = !valid_q || (m_axis_tready && last_beat);

	always_comb begin
		case (beat_q)
			BEAT_FLAG_OPEN:  frame_byte = cfg.flag_byte;
			BEAT_ADDR:       frame_byte = cfg.link_address;
			BEAT_CTRL:       frame_byte = cfg.set_control;
			BEAT_BCC:        frame_byte = cfg.link_address ^ cfg.set_control;
			BEAT_FLAG_CLOSE: frame_byte = cfg.flag_byte;
			default:         frame_byte = cfg.flag_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (valid_q && m_axis_tready) begin
			if (last_beat) valid_q <= 1'b0;
			else beat_q <= beat_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q  <= res.frame;
			status_q <= res.status;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = frame_q;
	assign m_axis_tlast  = last_beat;
	assign m_axis_tdata  = {6'd0, status_q, frame_q ? frame_byte : 8'd0};

	`SUA_ASSERT_IMPL(a_status_single_beat, clk, arst_n, valid_q && !frame_q, beat_q == '0)
	`SUA_ASSERT_NEXT(a_beat_step, clk, arst_n, valid_q && m_axis_tready && !last_beat, valid_q && beat_q == $past(beat_q) + BEAT_W'(1))

endmodule

FILE: hw/rtl/set_ua_link_setup_sender_core.sv
// ----------------------------------------------------------------------------
// SET/UA link-setup sender
// Sends SET frames, parses UA replies and retries on timeout.
// ----------------------------------------------------------------------------
// Each input beat is a start request, a received byte or a timer tick
// (tuser selects which). A start, or a timeout below the attempt limit,
// produces the five-beat SET frame with tuser high; every other request
// produces one status beat with tuser low and a zero byte. tlast marks the
// final beat of a request, and every beat carries the link status after
// that request. An input beat is registered and then resolved, so
// status-only requests stream at one beat per clock while tready is high;
// a SET frame holds the output for five beats, one frame byte per beat,
// during which one further request waits in the input register. Registers
// are written through the configuration channel, which is always ready.

module set_ua_link_setup_sender_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [9:8] link_status, rest zero
	output logic        m_axis_tuser,   // [0] tx_valid
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sua_pkg::*;

	cfg_t       cfg_q;
	logic       s1_valid_q;
	logic [1:0] req_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       free;
	res_t       res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd3;
			cfg_q.max_attempts  <= 4'd3;
			cfg_q.link_address  <= 8'h03;
			cfg_q.set_control   <= 8'h03;
			cfg_q.ua_control    <= 8'h07;
			cfg_q.flag_byte     <= 8'h7E;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMEOUT:  cfg_q.timeout_ticks <= cfg_data;
				CFG_MAX_ATT:  cfg_q.max_attempts  <= cfg_data[3:0];
				CFG_ADDRESS:  cfg_q.link_address  <= cfg_data[7:0];
				CFG_SET_CTRL: cfg_q.set_control   <= cfg_data[7:0];
				CFG_UA_CTRL:  cfg_q.ua_control    <= cfg_data[7:0];
				CFG_FLAG:     cfg_q.flag_byte     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign fire          = s1_valid_q && free;
	assign s_axis_tready = !s1_valid_q || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	sua_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.fire     (fire),
		.req_type (req_s1),
		.rx_byte  (byte_s1),
		.res      (res)
	);

	sua_tx_seq u_tx_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.load          (fire),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: tb/set_ua_link_setup_sender_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SET/UA link-setup sender testbench
// Drives start requests, received bytes and timer ticks into the sender under
// random idling on both streams. A scoreboard predicts every output beat
// (SET frame bytes and status beats) and compares each one in order.
// ----------------------------------------------------------------------------
module set_ua_link_setup_sender_core_test;
	import sua_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] status;
		logic       last;
	} link_beat_t;

	class link_setup_scoreboard;
		link_beat_t  pending_beats[$];
		int          errors;
		int          frames;
		int          connects;
		int          failures;
		logic [15:0] timeout_ticks;
		logic [3:0]  max_attempts;
		logic [7:0]  link_address;
		logic [7:0]  set_control;
		logic [7:0]  ua_control;
		logic [7:0]  flag_byte;
		parse_t      rx_state;
		logic [1:0]  link_phase;
		logic [15:0] tick_count;
		logic [3:0]  attempts;

		function new();
			timeout_ticks = 16'd3;
			max_attempts  = 4'd3;
			link_address  = 8'h03;
			set_control   = 8'h03;
			ua_control    = 8'h07;
			flag_byte     = 8'h7E;
			rx_state      = PS_FLAG;
			link_phase    = PH_IDLE;
			tick_count    = '0;
			attempts      = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				CFG_TIMEOUT:  timeout_ticks = value;
				CFG_MAX_ATT:  max_attempts  = value[3:0];
				CFG_ADDRESS:  link_address  = value[7:0];
				CFG_SET_CTRL: set_control   = value[7:0];
				CFG_UA_CTRL:  ua_control    = value[7:0];
				CFG_FLAG:     flag_byte     = value[7:0];
				default: ;
			endcase
		endfunction

		function void push_beat(logic valid, logic [7:0] data, logic lst);
			link_beat_t b;
			b.tx_valid = valid;
			b.tx_byte  = data;
			b.status   = link_phase;
			b.last     = lst;
			pending_beats.push_back(b);
		endfunction

		function void push_set_frame();
			tick_count = '0;
			frames++;
			push_beat(1'b1, flag_byte, 1'b0);
			push_beat(1'b1, link_address, 1'b0);
			push_beat(1'b1, set_control, 1'b0);
			push_beat(1'b1, link_address ^ set_control, 1'b0);
			push_beat(1'b1, flag_byte, 1'b1);
		endfunction

		function void parse_rx(logic [7:0] b);
			case (rx_state)
				PS_FLAG: if (b == flag_byte) rx_state = PS_ADDR;
				PS_ADDR: begin
					if (b == link_address) rx_state = PS_CTRL;
					else if (b != flag_byte) rx_state = PS_FLAG;
				end
				PS_CTRL: begin
					if (b == ua_control) rx_state = PS_BCC;
					else if (b == flag_byte) rx_state = PS_ADDR;
					else rx_state = PS_FLAG;
				end
				PS_BCC: begin
					if (b == (link_address ^ ua_control)) rx_state = PS_END;
					else if (b == flag_byte) rx_state = PS_ADDR;
					else rx_state = PS_FLAG;
				end
				default: begin
					if (b == flag_byte) begin
						link_phase = PH_CONN;
						tick_count = '0;
						connects++;
					end
					rx_state = PS_FLAG;
				end
			endcase
		endfunction

		function void note_request(logic [1:0] req, logic [7:0] b);
			logic [3:0] limit;
			if (req == REQ_START) begin
				rx_state   = PS_FLAG;
				attempts   = '0;
				link_phase = PH_WAIT;
				push_set_frame();
				return;
			end
			if (req == REQ_BYTE && link_phase == PH_WAIT) begin
				parse_rx(b);
			end else if (req == REQ_TICK && link_phase == PH_WAIT) begin
				tick_count = tick_count + 16'd1;
				if (tick_count >= timeout_ticks) begin
					limit = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
					tick_count = '0;
					attempts = attempts + 4'd1;
					if (attempts >= limit) begin
						link_phase = PH_FAIL;
						failures++;
					end else begin
						push_set_frame();
						return;
					end
				end
			end
			push_beat(1'b0, 8'h00, 1'b1);
		endfunction

		function void match(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_beat(logic [15:0] data, logic user, logic lst);
			link_beat_t e;
			if (pending_beats.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected beat, expected none, got data %04h user %0b last %0b",
						$time, data, user, lst);
				return;
			end
			e = pending_beats.pop_front();
			match("tx_valid", e.tx_valid, user);
			match("tx_byte", e.tx_byte, data[7:0]);
			match("link_status", e.status, data[9:8]);
			match("last", e.last, lst);
			match("tdata padding", 8'h00, data[15:10]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	link_setup_scoreboard link_sb;
	bit send_idle;
	bit stall_on;
	int batch_items;
	int in_beats;
	int out_beats;
	int settings;
	int quiet_cycles;

	set_ua_link_setup_sender_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				link_sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
				out_beats++;
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic drive_item(input logic [1:0] req, input logic [7:0] b);
		batch_items++;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		link_sb.note_request(req, b);
		in_beats++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		link_sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [15:0] tmo, input logic [3:0] max_att,
			input logic [7:0] addr, input logic [7:0] set_ctrl,
			input logic [7:0] ua_ctrl, input logic [7:0] flag);
		write_reg(CFG_TIMEOUT, tmo);
		write_reg(CFG_MAX_ATT, {12'd0, max_att});
		write_reg(CFG_ADDRESS, {8'd0, addr});
		write_reg(CFG_SET_CTRL, {8'd0, set_ctrl});
		write_reg(CFG_UA_CTRL, {8'd0, ua_ctrl});
		write_reg(CFG_FLAG, {8'd0, flag});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (link_sb.pending_beats.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic run_random(input int target);
		logic [7:0] ua[5];
		int k;
		int cap;
		int pick;
		batch_items = 0;
		while (batch_items < target) begin
			pick = $urandom_range(0, 99);
			if (link_sb.link_phase != PH_WAIT && $urandom_range(0, 3) != 0) begin
				drive_item(REQ_START, 8'($urandom));
			end else if (pick < 45) begin
				ua[0] = link_sb.flag_byte;
				ua[1] = link_sb.link_address;
				ua[2] = link_sb.ua_control;
				ua[3] = link_sb.link_address ^ link_sb.ua_control;
				ua[4] = link_sb.flag_byte;
				if ($urandom_range(0, 3) == 0) ua[$urandom_range(0, 4)] = 8'($urandom);
				if ($urandom_range(0, 4) == 0) drive_item(REQ_BYTE, link_sb.flag_byte);
				for (k = 0; k < 5; k++) begin
					if ($urandom_range(0, 6) == 0) drive_item(REQ_TICK, 8'($urandom));
					drive_item(REQ_BYTE, ua[k]);
				end
			end else if (pick < 70) begin
				cap = (link_sb.timeout_ticks > 16'd6) ? 6 : int'(link_sb.timeout_ticks) + 1;
				repeat ($urandom_range(1, cap)) drive_item(REQ_TICK, 8'($urandom));
			end else if (pick < 85) begin
				drive_item(REQ_BYTE, $urandom_range(0, 1) ? link_sb.flag_byte : 8'($urandom));
			end else if (pick < 93) begin
				drive_item(REQ_START, 8'($urandom));
			end else begin
				drive_item(REQ_UNUSED, 8'($urandom));
			end
		end
		drain();
	endtask

	initial begin
		link_sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_START;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = '0;
		send_idle = 1'b1;
		stall_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: idle requests, a clean UA, a resync on a doubled
		// flag, and a UA split across a retransmission.
		drive_item(REQ_TICK, 8'h00);
		drive_item(REQ_BYTE, 8'hFF);
		drive_item(REQ_UNUSED, 8'h00);
		drive_item(REQ_START, 8'hFF);
		drive_item(REQ_BYTE, link_sb.flag_byte);
		drive_item(REQ_BYTE, link_sb.flag_byte);
		drive_item(REQ_BYTE, link_sb.link_address);
		drive_item(REQ_BYTE, link_sb.ua_control);
		drive_item(REQ_BYTE, link_sb.link_address ^ link_sb.ua_control);
		drive_item(REQ_BYTE, link_sb.flag_byte);
		drive_item(REQ_BYTE, 8'h55);
		drive_item(REQ_TICK, 8'hAA);
		drive_item(REQ_START, 8'h00);
		drive_item(REQ_BYTE, link_sb.flag_byte);
		drive_item(REQ_BYTE, link_sb.link_address);
		repeat (3) drive_item(REQ_TICK, 8'h00);
		drive_item(REQ_BYTE, link_sb.ua_control);
		drive_item(REQ_BYTE, link_sb.link_address ^ link_sb.ua_control);
		drive_item(REQ_BYTE, link_sb.flag_byte);
		drain();

		// Zero timeout and zero attempt limit: the first tick fails the link.
		load_settings(16'd0, 4'd0, 8'h00, 8'hFF, 8'h55, 8'h7E);
		drive_item(REQ_START, 8'h00);
		drive_item(REQ_TICK, 8'h00);
		run_random(20);

		load_settings(16'd1, 4'd15, 8'hFF, 8'h00, 8'hFF, 8'h00);
		run_random(30);

		load_settings(16'hFFFF, 4'd1, 8'h7E, 8'h81, 8'h7E, 8'h7E);
		run_random(15);

		load_settings(16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		run_random(35);

		load_settings(16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		run_random(30);

		send_idle = 1'b0;
		stall_on = 1'b0;
		load_settings(16'($urandom_range(1, 4)), 4'($urandom_range(1, 15)), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		run_random(20);

		$display("Sent %0d request beats and checked %0d result beats under %0d register settings.",
			in_beats, out_beats, settings + 1);
		$display("The stream held %0d SET frames, %0d completed UA replies and %0d failed setups.",
			link_sb.frames, link_sb.connects, link_sb.failures);
		if (link_sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
